// ===== rtl/humidity_temperature_compensation_assert.svh =====
// Assertion macros for the humidity and temperature compensation block
`ifndef HUMIDITY_TEMPERATURE_COMPENSATION_ASSERT_SVH
`define HUMIDITY_TEMPERATURE_COMPENSATION_ASSERT_SVH
`ifndef SYNTHESIS
`define HTC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("htc assertion failed");
`define HTC_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("htc assertion failed");
`else
`define HTC_ASSERT(lbl, clk, rst_n, prop)
`define HTC_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

// ===== rtl/htc_pkg.sv =====
// Package: types and constants of the humidity and temperature compensation block
`default_nettype none
package htc_pkg;

  localparam int FRAC_BITS_DEF   = 8;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int FRONT_STAGES    = 2;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int RAW_W      = 16;
  localparam int HREF_W     = 8;
  localparam int TREF_W     = 10;
  localparam int VALUE_W    = 24;

  localparam int DX_W       = RAW_W + 1;
  localparam int DY_W       = TREF_W + 1;
  localparam int DEN_W      = RAW_W;
  localparam int MAG_PROD_W = RAW_W + TREF_W;

  // log2 of the reference divisors: half percent and eighth degree
  localparam int HUM_SHIFT  = 1;
  localparam int TEMP_SHIFT = 3;

  localparam logic [CFG_IDX_W-1:0] REG_HUM_REF_LOW   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_REF_HIGH  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_REF_LOW  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_REF_HIGH = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_RAW_LOW   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_RAW_HIGH  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_RAW_LOW  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_RAW_HIGH = 4'd7;

  localparam logic ACT_HUM  = 1'b0;
  localparam logic ACT_TEMP = 1'b1;

  localparam logic signed [VALUE_W-1:0] VAL_MAX = 24'sh7FFFFF;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = -24'sh800000;

  typedef struct packed {
    logic                    action;
    logic signed [RAW_W-1:0] raw_sample;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      zero_span;
    logic                      saturated;
  } out_word_t;

  typedef struct packed {
    logic [HREF_W-1:0]       hum_ref_low;
    logic [HREF_W-1:0]       hum_ref_high;
    logic [TREF_W-1:0]       temp_ref_low;
    logic [TREF_W-1:0]       temp_ref_high;
    logic signed [RAW_W-1:0] hum_raw_low;
    logic signed [RAW_W-1:0] hum_raw_high;
    logic signed [RAW_W-1:0] temp_raw_low;
    logic signed [RAW_W-1:0] temp_raw_high;
  } cfg_regs_t;

endpackage
`default_nettype wire

// ===== rtl/htc_cfg.sv =====
// Calibration register file
`default_nettype none
module htc_cfg import htc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_valid_i,
  output logic                       wr_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  wr_index_i,
  input  wire logic [CFG_DATA_W-1:0] wr_data_i,
  output cfg_regs_t                  regs_o
);

  cfg_regs_t cfg_r;
  cfg_regs_t cfg_nxt;

  assign wr_ready_o = 1'b1;
  assign regs_o     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_valid_i) begin
      case (wr_index_i)
        REG_HUM_REF_LOW:   cfg_nxt.hum_ref_low   = wr_data_i[HREF_W-1:0];
        REG_HUM_REF_HIGH:  cfg_nxt.hum_ref_high  = wr_data_i[HREF_W-1:0];
        REG_TEMP_REF_LOW:  cfg_nxt.temp_ref_low  = wr_data_i[TREF_W-1:0];
        REG_TEMP_REF_HIGH: cfg_nxt.temp_ref_high = wr_data_i[TREF_W-1:0];
        REG_HUM_RAW_LOW:   cfg_nxt.hum_raw_low   = wr_data_i[RAW_W-1:0];
        REG_HUM_RAW_HIGH:  cfg_nxt.hum_raw_high  = wr_data_i[RAW_W-1:0];
        REG_TEMP_RAW_LOW:  cfg_nxt.temp_raw_low  = wr_data_i[RAW_W-1:0];
        REG_TEMP_RAW_HIGH: cfg_nxt.temp_raw_high = wr_data_i[RAW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/htc_front.sv =====
// Front end: selects calibration set, forms differences, magnitudes and product
`default_nettype none
module htc_front import htc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int NUM_W    = MAG_PROD_W + FRAC_BITS - HUM_SHIFT,
  localparam int OFS_W    = TREF_W + FRAC_BITS - TEMP_SHIFT,
  localparam int ENTRY_W  = NUM_W + OFS_W + DEN_W + 2
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      accept_i,
  input  wire in_word_t  in_word_i,
  input  wire cfg_regs_t cfg_i,
  output logic           push_o,
  output logic [ENTRY_W-1:0] entry_o
);

  logic [RAW_W-1:0]  x0;
  logic [RAW_W-1:0]  x1;
  logic [TREF_W-1:0] y0;
  logic [TREF_W-1:0] y1;
  logic [DX_W-1:0]   dx_nxt;
  logic [DX_W-1:0]   dxr_nxt;
  logic [DY_W-1:0]   dy_nxt;
  logic [OFS_W-1:0]  ofs_nxt;
  logic              temp_nxt;

  logic              s1_valid_r;
  logic [DX_W-1:0]   s1_dx_r;
  logic [DX_W-1:0]   s1_dxr_r;
  logic [DY_W-1:0]   s1_dy_r;
  logic [OFS_W-1:0]  s1_ofs_r;
  logic              s1_temp_r;

  logic [DX_W-1:0]       dx_abs;
  logic [DX_W-1:0]       dxr_abs;
  logic [DY_W-1:0]       dy_abs;
  logic [MAG_PROD_W-1:0] prod;
  logic [NUM_W-1:0]      num_nxt;

  logic              s2_valid_r;
  logic [NUM_W-1:0]  s2_num_r;
  logic [DEN_W-1:0]  s2_den_r;
  logic [OFS_W-1:0]  s2_ofs_r;
  logic              s2_neg_r;
  logic              s2_zero_r;

  always_comb begin
    temp_nxt = (in_word_i.action == ACT_TEMP);
    if (temp_nxt) begin
      x0      = cfg_i.temp_raw_low;
      x1      = cfg_i.temp_raw_high;
      y0      = cfg_i.temp_ref_low;
      y1      = cfg_i.temp_ref_high;
      ofs_nxt = OFS_W'(y0) << (FRAC_BITS - TEMP_SHIFT);
    end else begin
      x0      = cfg_i.hum_raw_low;
      x1      = cfg_i.hum_raw_high;
      y0      = {{(TREF_W-HREF_W){1'b0}}, cfg_i.hum_ref_low};
      y1      = {{(TREF_W-HREF_W){1'b0}}, cfg_i.hum_ref_high};
      ofs_nxt = OFS_W'(y0) << (FRAC_BITS - HUM_SHIFT);
    end
    dx_nxt  = {in_word_i.raw_sample[RAW_W-1], in_word_i.raw_sample} - {x0[RAW_W-1], x0};
    dxr_nxt = {x1[RAW_W-1], x1} - {x0[RAW_W-1], x0};
    dy_nxt  = {1'b0, y1} - {1'b0, y0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept_i;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_i) begin
      s1_dx_r   <= dx_nxt;
      s1_dxr_r  <= dxr_nxt;
      s1_dy_r   <= dy_nxt;
      s1_ofs_r  <= ofs_nxt;
      s1_temp_r <= temp_nxt;
    end
  end

  always_comb begin
    dx_abs  = s1_dx_r[DX_W-1]  ? (~s1_dx_r + 1'b1)  : s1_dx_r;
    dxr_abs = s1_dxr_r[DX_W-1] ? (~s1_dxr_r + 1'b1) : s1_dxr_r;
    dy_abs  = s1_dy_r[DY_W-1]  ? (~s1_dy_r + 1'b1)  : s1_dy_r;
    prod    = dx_abs[RAW_W-1:0] * dy_abs[TREF_W-1:0];
    if (s1_temp_r) begin
      num_nxt = NUM_W'(prod) << (FRAC_BITS - TEMP_SHIFT);
    end else begin
      num_nxt = NUM_W'(prod) << (FRAC_BITS - HUM_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      s2_num_r  <= num_nxt;
      s2_den_r  <= dxr_abs[DEN_W-1:0];
      s2_ofs_r  <= s1_ofs_r;
      s2_neg_r  <= s1_dx_r[DX_W-1] ^ s1_dy_r[DY_W-1] ^ s1_dxr_r[DX_W-1];
      s2_zero_r <= (s1_dxr_r == '0);
    end
  end

  assign push_o  = s2_valid_r;
  assign entry_o = {s2_neg_r, s2_zero_r, s2_den_r, s2_ofs_r, s2_num_r};

endmodule
`default_nettype wire

// ===== rtl/htc_fifo.sv =====
// Short queue between front end and divider back end
`default_nettype none
`include "humidity_temperature_compensation_assert.svh"
module htc_fifo import htc_pkg::*; #(
  parameter int WIDTH     = 8,
  parameter int DEPTH     = QUEUE_DEPTH_DEF,
  localparam int PTR_W    = $clog2(DEPTH),
  localparam int CNT_W    = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] din_i,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      dout_o,
  output logic [CNT_W-1:0]      count_o
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] dout_r;
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_i && !push_i) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // head word registered from the next read address; a word written there bypasses
  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= din_i;
    end
    if (push_i && (wr_ptr_r == rd_ptr_nxt)) begin
      dout_r <= din_i;
    end else begin
      dout_r <= mem_r[rd_ptr_nxt];
    end
  end

  assign dout_o  = dout_r;
  assign count_o = count_r;

  `HTC_ASSERT(a_no_overflow, clk, rst_n, push_i && !pop_i |-> count_r < CNT_W'(DEPTH))
  `HTC_ASSERT(a_no_underflow, clk, rst_n, pop_i |-> count_r != '0)
  `HTC_ASSERT_NORST(a_reset_empty, clk, !rst_n |=> count_r == '0)

endmodule
`default_nettype wire

// ===== rtl/htc_back.sv =====
// Back end: bit-per-stage restoring divider, sign, offset, zero-span flag and saturation
`default_nettype none
`include "humidity_temperature_compensation_assert.svh"
module htc_back import htc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int NUM_W    = MAG_PROD_W + FRAC_BITS - HUM_SHIFT,
  localparam int OFS_W    = TREF_W + FRAC_BITS - TEMP_SHIFT,
  localparam int ENTRY_W  = NUM_W + OFS_W + DEN_W + 2,
  localparam int SUM_W    = NUM_W + 2
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               entry_valid_i,
  input  wire logic [ENTRY_W-1:0] entry_i,
  output logic                    out_valid_o,
  output out_word_t               out_word_o
);

  logic             st_valid_r [NUM_W];
  logic [DEN_W-1:0] st_rem_r   [NUM_W];
  logic [NUM_W-1:0] st_nq_r    [NUM_W];
  logic [DEN_W-1:0] st_den_r   [NUM_W];
  logic [OFS_W-1:0] st_ofs_r   [NUM_W];
  logic             st_neg_r   [NUM_W];
  logic             st_zero_r  [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_div
    logic             vld_in;
    logic [DEN_W-1:0] rem_in;
    logic [NUM_W-1:0] nq_in;
    logic [DEN_W-1:0] den_in;
    logic [OFS_W-1:0] ofs_in;
    logic             neg_in;
    logic             zero_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [DEN_W-1:0] rem_nxt;
    logic [NUM_W-1:0] nq_nxt;

    if (k == 0) begin : g_head
      assign vld_in  = entry_valid_i;
      assign rem_in  = '0;
      assign nq_in   = entry_i[NUM_W-1:0];
      assign ofs_in  = entry_i[NUM_W +: OFS_W];
      assign den_in  = entry_i[NUM_W + OFS_W +: DEN_W];
      assign zero_in = entry_i[ENTRY_W-2];
      assign neg_in  = entry_i[ENTRY_W-1];
    end else begin : g_link
      assign vld_in  = st_valid_r[k-1];
      assign rem_in  = st_rem_r[k-1];
      assign nq_in   = st_nq_r[k-1];
      assign ofs_in  = st_ofs_r[k-1];
      assign den_in  = st_den_r[k-1];
      assign zero_in = st_zero_r[k-1];
      assign neg_in  = st_neg_r[k-1];
    end

    // numerator bits shift out at the top, quotient bits shift in at the bottom
    assign trial   = {rem_in, nq_in[NUM_W-1]};
    assign ge      = (trial >= {1'b0, den_in});
    assign diff    = trial - {1'b0, den_in};
    assign rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    assign nq_nxt  = {nq_in[NUM_W-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_valid_r[k] <= 1'b0;
      end else begin
        st_valid_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      st_rem_r[k]  <= rem_nxt;
      st_nq_r[k]   <= nq_nxt;
      st_den_r[k]  <= den_in;
      st_ofs_r[k]  <= ofs_in;
      st_neg_r[k]  <= neg_in;
      st_zero_r[k] <= zero_in;
    end
  end

  logic                    sg_valid_r;
  logic signed [NUM_W:0]   sg_q_r;
  logic [NUM_W:0]          q_ext;
  logic [NUM_W:0]          q_nxt;
  logic [OFS_W-1:0]        sg_ofs_r;
  logic                    sg_zero_r;

  assign q_ext = {1'b0, st_nq_r[NUM_W-1]};
  assign q_nxt = st_neg_r[NUM_W-1] ? (~q_ext + 1'b1) : q_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sg_valid_r <= 1'b0;
    end else begin
      sg_valid_r <= st_valid_r[NUM_W-1];
    end
  end

  always_ff @(posedge clk) begin
    sg_q_r    <= q_nxt;
    sg_ofs_r  <= st_ofs_r[NUM_W-1];
    sg_zero_r <= st_zero_r[NUM_W-1];
  end

  logic signed [SUM_W-1:0] sum;
  logic                    out_valid_r;
  out_word_t               out_word_r;
  out_word_t               out_word_nxt;

  always_comb begin
    sum = SUM_W'(sg_q_r) + SUM_W'($signed({1'b0, sg_ofs_r}));
    out_word_nxt.zero_span = 1'b0;
    out_word_nxt.saturated = 1'b0;
    out_word_nxt.value     = sum[VALUE_W-1:0];
    if (sg_zero_r) begin
      out_word_nxt.zero_span = 1'b1;
      out_word_nxt.value     = '0;
    end else if (sum > SUM_W'(VAL_MAX)) begin
      out_word_nxt.saturated = 1'b1;
      out_word_nxt.value     = VAL_MAX;
    end else if (sum < SUM_W'(VAL_MIN)) begin
      out_word_nxt.saturated = 1'b1;
      out_word_nxt.value     = VAL_MIN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= sg_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid_o = out_valid_r;
  assign out_word_o  = out_word_r;

  `HTC_ASSERT(a_sat_at_rail, clk, rst_n, out_valid_r && out_word_r.saturated |-> out_word_r.value == VAL_MAX || out_word_r.value == VAL_MIN)
  `HTC_ASSERT(a_zero_span_flags, clk, rst_n, sg_valid_r && sg_zero_r |=> out_valid_r && out_word_r.zero_span && !out_word_r.saturated)

endmodule
`default_nettype wire

// ===== rtl/humidity_temperature_compensation.sv =====
// Top level: two-point linear compensation of humidity and temperature samples
// Throughput: one sample per cycle while busy is low; the divider retires one quotient
// bit per stage over FRAC_BITS + 25 pipelined stages and the receiver cannot stall it.
// busy rises only when the queue between front end and divider nears full.
// Reset: synchronous, active low; calibration registers clear to zero, pipeline empties.
`default_nettype none
module humidity_temperature_compensation import htc_pkg::*; #(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire in_word_t              in_word,
  output logic                       out_valid,
  output out_word_t                  out_word,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NUM_W   = MAG_PROD_W + FRAC_BITS - HUM_SHIFT;
  localparam int OFS_W   = TREF_W + FRAC_BITS - TEMP_SHIFT;
  localparam int ENTRY_W = NUM_W + OFS_W + DEN_W + 2;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);

  cfg_regs_t          cfg_regs;
  logic               accept;
  logic               push;
  logic [ENTRY_W-1:0] push_entry;
  logic [ENTRY_W-1:0] head_entry;
  logic [CNT_W-1:0]   q_count;
  logic               pop;

  // room must remain for every word still in the front end
  assign busy   = (q_count >= CNT_W'(QUEUE_DEPTH - FRONT_STAGES));
  assign accept = start && !busy;
  assign pop    = (q_count != '0);

  htc_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_valid_i (cfg_valid),
    .wr_ready_o (cfg_ready),
    .wr_index_i (cfg_index),
    .wr_data_i  (cfg_data),
    .regs_o     (cfg_regs)
  );

  htc_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept_i  (accept),
    .in_word_i (in_word),
    .cfg_i     (cfg_regs),
    .push_o    (push),
    .entry_o   (push_entry)
  );

  htc_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .din_i   (push_entry),
    .pop_i   (pop),
    .dout_o  (head_entry),
    .count_o (q_count)
  );

  htc_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .entry_valid_i (pop),
    .entry_i       (head_entry),
    .out_valid_o   (out_valid),
    .out_word_o    (out_word)
  );

endmodule
`default_nettype wire

// ===== tb/humidity_temperature_compensation_checker.sv =====
// Checker: predicts each compensated reading from the calibration writes seen and compares
module humidity_temperature_compensation_checker import htc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  in_word_t              in_word,
  input  logic                  out_valid,
  input  out_word_t             out_word,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    in_flight,
  output int                    mismatches
);

  cfg_regs_t cal;
  out_word_t predicted_readings[$];
  out_word_t want;

  function automatic out_word_t compensate(in_word_t w, cfg_regs_t c);
    longint x, lo, hi, ref_lo, ref_hi, div, den, num, v;
    out_word_t r;
    x = $signed(w.raw_sample);
    if (w.action == ACT_TEMP) begin
      lo     = $signed(c.temp_raw_low);
      hi     = $signed(c.temp_raw_high);
      ref_lo = c.temp_ref_low;
      ref_hi = c.temp_ref_high;
      div    = longint'(1) << TEMP_SHIFT;
    end else begin
      lo     = $signed(c.hum_raw_low);
      hi     = $signed(c.hum_raw_high);
      ref_lo = c.hum_ref_low;
      ref_hi = c.hum_ref_high;
      div    = longint'(1) << HUM_SHIFT;
    end
    r   = '0;
    den = (hi - lo) * div;
    if (den == 0) begin
      r.zero_span = 1'b1;
    end else begin
      num = (x - lo) * (ref_hi - ref_lo) * (longint'(1) << FRAC_BITS);
      // division truncates toward zero, offset is exact
      v = num / den + (ref_lo << FRAC_BITS) / div;
      if (v > longint'(VAL_MAX)) begin
        v           = VAL_MAX;
        r.saturated = 1'b1;
      end else if (v < longint'(VAL_MIN)) begin
        v           = VAL_MIN;
        r.saturated = 1'b1;
      end
      r.value = v[VALUE_W-1:0];
    end
    return r;
  endfunction

  initial begin
    in_flight  = 0;
    mismatches = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      cal <= '0;
      predicted_readings.delete();
      in_flight <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HUM_REF_LOW:   cal.hum_ref_low   <= cfg_data[HREF_W-1:0];
          REG_HUM_REF_HIGH:  cal.hum_ref_high  <= cfg_data[HREF_W-1:0];
          REG_TEMP_REF_LOW:  cal.temp_ref_low  <= cfg_data[TREF_W-1:0];
          REG_TEMP_REF_HIGH: cal.temp_ref_high <= cfg_data[TREF_W-1:0];
          REG_HUM_RAW_LOW:   cal.hum_raw_low   <= cfg_data[RAW_W-1:0];
          REG_HUM_RAW_HIGH:  cal.hum_raw_high  <= cfg_data[RAW_W-1:0];
          REG_TEMP_RAW_LOW:  cal.temp_raw_low  <= cfg_data[RAW_W-1:0];
          REG_TEMP_RAW_HIGH: cal.temp_raw_high <= cfg_data[RAW_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy)
        predicted_readings.push_back(compensate(in_word, cal));
      if (out_valid) begin
        if (predicted_readings.size() == 0) begin
          $error("result word with nothing expected: value %0d", $signed(out_word.value));
          mismatches++;
        end else begin
          want = predicted_readings.pop_front();
          if (out_word.value !== want.value) begin
            $error("value: expected %0d, got %0d", $signed(want.value),
                   $signed(out_word.value));
            mismatches++;
          end
          if (out_word.zero_span !== want.zero_span) begin
            $error("zero_span: expected %0b, got %0b", want.zero_span, out_word.zero_span);
            mismatches++;
          end
          if (out_word.saturated !== want.saturated) begin
            $error("saturated: expected %0b, got %0b", want.saturated, out_word.saturated);
            mismatches++;
          end
        end
      end
      in_flight <= predicted_readings.size();
    end
  end

endmodule

// ===== tb/humidity_temperature_compensation_test.sv =====
// Testbench top: calibration phases and sample stimulus for the compensation block
module humidity_temperature_compensation_test;
  import htc_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASES        = 6;
  localparam int WORDS_A_PHASE = 175;
  localparam logic [CFG_IDX_W-1:0] REG_PAST_END = 4'd8;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_IDX  = {CFG_IDX_W{1'b1}};

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  in_word_t              in_word   = '0;
  logic                  out_valid;
  out_word_t             out_word;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  int                    in_flight;
  int                    mismatches;
  int                    cycles    = 0;

  humidity_temperature_compensation dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  humidity_temperature_compensation_checker watch (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_word   (out_word),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_flight  (in_flight),
    .mismatches (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("humidity_temperature_compensation_test: done, errors");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_cal(logic [15:0] hrl, logic [15:0] hrh, logic [15:0] trl,
                             logic [15:0] trh, logic [15:0] hxl, logic [15:0] hxh,
                             logic [15:0] txl, logic [15:0] txh);
    write_reg(REG_HUM_REF_LOW, hrl);
    write_reg(REG_HUM_REF_HIGH, hrh);
    write_reg(REG_TEMP_REF_LOW, trl);
    write_reg(REG_TEMP_REF_HIGH, trh);
    write_reg(REG_HUM_RAW_LOW, hxl);
    write_reg(REG_HUM_RAW_HIGH, hxh);
    write_reg(REG_TEMP_RAW_LOW, txl);
    write_reg(REG_TEMP_RAW_HIGH, txh);
  endtask

  // leaves start high so that a following word goes back to back
  task automatic send_sample(logic act, logic [RAW_W-1:0] raw);
    start   <= 1'b1;
    in_word <= in_word_t'{act, raw};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [15:0] raw_partner(logic [15:0] lo);
    case ($urandom_range(7, 0))
      0:       return lo;
      1:       return lo + 16'($urandom_range(4, 1));
      2:       return lo - 16'($urandom_range(4, 1));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] random_raw();
    case ($urandom_range(7, 0))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_phase();
    logic [15:0] hlo, tlo;
    int left, burst;
    hlo = 16'($urandom);
    tlo = 16'($urandom);
    program_cal(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                hlo, raw_partner(hlo), tlo, raw_partner(tlo));
    if ($urandom_range(1, 0) == 1)
      write_reg(4'($urandom_range(REG_TOP_IDX, REG_PAST_END)), 16'($urandom));
    left = WORDS_A_PHASE;
    while (left > 0) begin
      burst = $urandom_range(24, 1);
      while (burst > 0 && left > 0) begin
        send_sample(1'($urandom), random_raw());
        burst--;
        left--;
      end
      if ($urandom_range(40, 0) == 0)
        drain();
      else if ($urandom_range(2, 0) != 0)
        pause($urandom_range(8, 1));
    end
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // calibration still at reset: both spans zero
    send_sample(ACT_HUM, 16'h0000);
    send_sample(ACT_TEMP, 16'h8000);
    drain();

    // typical points, junk above the register widths
    program_cal(16'hFF28, 16'hABA0, 16'hFC50, 16'hFD18,
                -16'sd5000, 16'sd8000, 16'sd300, 16'sd700);
    write_reg(REG_PAST_END, 16'hFFFF);
    write_reg(REG_TOP_IDX, 16'h0000);
    send_sample(ACT_HUM, 16'h7FFF);
    send_sample(ACT_HUM, 16'h8000);
    send_sample(ACT_HUM, -16'sd5000);
    send_sample(ACT_HUM, 16'sd8000);
    send_sample(ACT_HUM, 16'h0000);
    send_sample(ACT_HUM, 16'hFFFF);
    send_sample(ACT_TEMP, 16'h7FFF);
    send_sample(ACT_TEMP, 16'h8000);
    send_sample(ACT_TEMP, 16'sd300);
    send_sample(ACT_TEMP, 16'sd700);
    send_sample(ACT_TEMP, 16'sd500);
    drain();

    // span of one raw count: clamps both ways, temperature reversed
    program_cal(16'd0, 16'd255, 16'd1023, 16'd0, 16'd0, 16'd1, 16'd1, 16'd0);
    send_sample(ACT_HUM, 16'h7FFF);
    send_sample(ACT_HUM, 16'h8000);
    send_sample(ACT_HUM, 16'd1);
    send_sample(ACT_HUM, 16'd0);
    send_sample(ACT_TEMP, 16'h7FFF);
    send_sample(ACT_TEMP, 16'h8000);
    send_sample(ACT_TEMP, 16'd1);
    send_sample(ACT_TEMP, 16'd0);
    drain();

    // widest raw spans, full reference ranges
    program_cal(16'd255, 16'd0, 16'd0, 16'd1023, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
    send_sample(ACT_HUM, 16'h7FFF);
    send_sample(ACT_TEMP, 16'h8000);
    drain();

    repeat (PHASES) random_phase();

    repeat (FRAC_BITS_DEF + 29) @(posedge clk);
    if (mismatches == 0 && in_flight == 0)
      $display("humidity_temperature_compensation_test: done, clean");
    else
      $display("humidity_temperature_compensation_test: done, errors");
    $finish;
  end

endmodule
